/* sv/otmf_pkg.sv */
// ----------------------------------------------------------------------------
// otmf_pkg
// Types and constants shared by the trimmed mean ORP filter and its divider.
// ----------------------------------------------------------------------------
package otmf_pkg;

   localparam int QUOT_W      = 15;
   localparam int NUM_W       = 36;
   localparam int DSR_W       = 21;
   localparam int T_W         = 21;
   localparam int DIVD_W      = 22;
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 30;
   localparam int ORP_FRAC    = 14;

   localparam logic [T_W-1:0]   ORP_SCALE = T_W'(491520);
   localparam logic [6:0]       MEAN_GAIN = 7'd75;
   localparam logic [DSR_W-1:0] ORP_DEN   = DSR_W'(1228800);

   localparam logic [RECIP_W-1:0] ORP_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MEAN_GAIN) - 64'd1) / 64'(MEAN_GAIN));

   localparam logic [12:0] VREF_RESET   = 13'd5000;
   localparam logic [11:0] OFFSET_RESET = 12'd0;
   localparam logic [9:0]  SAMPLE_MAX   = 10'd1023;

   localparam logic [13:0] ORP_MAX     = 14'h1FFF;
   localparam logic [13:0] ORP_MIN     = 14'h2000;
   localparam logic [QUOT_W-1:0] ORP_POS_LIM = QUOT_W'(8191);
   localparam logic [QUOT_W-1:0] ORP_NEG_LIM = QUOT_W'(8192);

   localparam logic CSR_VREF_IDX   = 1'b0;
   localparam logic CSR_OFFSET_IDX = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_MSTART,
      ST_MDIV,
      ST_MUL1,
      ST_MUL2,
      ST_SUB,
      ST_OSTART,
      ST_ODIV,
      ST_OUT
   } state_type;

endpackage

/* sv/otmf_div.sv */
// ----------------------------------------------------------------------------
// otmf_div
// Constant divider: multiply by a scaled reciprocal and drop the fraction
// bits. The quotient is registered and follows in the cycle after start.
// ----------------------------------------------------------------------------
module otmf_div
   import otmf_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [DIVD_W-1:0]   dividend,
   input  logic [RECIP_W-1:0]  recip,
   output logic                done,
   output logic [QUOT_W-1:0]   quotient
);

   localparam int PROD_W = DIVD_W + RECIP_W;

   logic              done_ff, done_in;
   logic [QUOT_W-1:0] quo_ff, quo_in;
   logic [PROD_W-1:0] prod;

   always_comb begin
      done_in = start;
      prod    = PROD_W'(dividend) * PROD_W'(recip);
      quo_in  = start ? prod[RECIP_SHIFT +: QUOT_W] : quo_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* sv/orp_trimmed_mean_filter.sv */
// ----------------------------------------------------------------------------
// orp_trimmed_mean_filter
// Moving trimmed mean of converter samples over a ring, scaled to ORP in mV.
//
//   channel   direction  payload
//   req_      in         tdata[9:0] sample
//   rsp_      out        tdata[13:0] orp_mv, tdata[27:14] trimmed_mean
//   csr_      in         vref_mv at 0x0, offset_mv at 0x4
//
// Each request runs a ring walk of one memory read per entry, then a
// reciprocal multiply for the mean and another for the millivolt scaling.
// req_tready stays low until the result is posted and rsp_tvalid rises.
// Reset empties the ring at once through a fill count.
// A new request is taken while a finished result still waits on rsp_.
// ----------------------------------------------------------------------------
module orp_trimmed_mean_filter
   import otmf_pkg::*;
#(
   parameter int RING_DEPTH = 40
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [9:0] sample
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [13:0] orp_mv, [27:14] trimmed_mean
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int FW = $clog2(RING_DEPTH + 1);
   localparam int SW = $clog2(RING_DEPTH * 1023 + 1);
   localparam bit TRIM = (RING_DEPTH >= 5);
   localparam int MEAN_DIV = TRIM ? RING_DEPTH - 2 : RING_DEPTH;
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic [FW-1:0] FILL_FULL = FW'(RING_DEPTH);
   localparam logic [RECIP_W-1:0] MEAN_RECIP =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'(MEAN_DIV) - 64'd1) / 64'(MEAN_DIV));

   logic [9:0] ring_mem [RING_DEPTH];
   logic [9:0] rd_data_ff;

   state_type         state_ff, state_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [AW-1:0]     slot_ff, slot_in;
   logic [FW-1:0]     fill_ff, fill_in;
   logic              rd_pend_ff, rd_pend_in;
   logic              rd_live_ff, rd_live_in;
   logic [SW-1:0]     sum_ff, sum_in;
   logic [9:0]        lo_ff, lo_in;
   logic [9:0]        hi_ff, hi_in;
   logic [13:0]       mean_ff, mean_in;
   logic [T_W-1:0]    t_ff, t_in;
   logic signed [34:0] prod_ff, prod_in;
   logic signed [33:0] ofs_ff, ofs_in;
   logic signed [NUM_W-1:0] num_ff, num_in;
   logic [QUOT_W-1:0] omag_ff, omag_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [13:0]       orp_out_ff, orp_out_in;
   logic [13:0]       mean_out_ff, mean_out_in;
   logic [12:0]       vref_ff;
   logic [11:0]       offset_ff;

   logic              mem_we;
   logic [9:0]        rd_val;
   logic [SW-1:0]     trimmed;
   logic              div_start;
   logic              div_orp;
   logic [DIVD_W-1:0] div_dividend;
   logic [RECIP_W-1:0] div_recip;
   logic              div_done;
   logic [QUOT_W-1:0] div_quot;
   logic [NUM_W-1:0]  num_mag;
   logic              csr_wr;

   otmf_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .recip    (div_recip),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rd_val  = rd_live_ff ? rd_data_ff : 10'd0;
   assign trimmed = TRIM ? (sum_ff - SW'(lo_ff) - SW'(hi_ff)) : sum_ff;
   assign num_mag = num_ff[NUM_W-1] ? NUM_W'(-num_ff) : NUM_W'(num_ff);
   assign div_dividend = div_orp ? num_mag[NUM_W-1:ORP_FRAC]
                                 : DIVD_W'({trimmed, 4'b0000});
   assign div_recip    = div_orp ? ORP_RECIP : MEAN_RECIP;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      rd_pend_in   = 1'b0;
      rd_live_in   = rd_live_ff;
      sum_in       = sum_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mean_in      = mean_ff;
      t_in         = t_ff;
      prod_in      = prod_ff;
      ofs_in       = ofs_ff;
      num_in       = num_ff;
      omag_in      = omag_ff;
      rsp_valid_in = rsp_valid_ff;
      orp_out_in   = orp_out_ff;
      mean_out_in  = mean_out_ff;
      mem_we       = 1'b0;
      div_start    = 1'b0;
      div_orp      = 1'b0;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // fold in the entry read last cycle
      if (rd_pend_ff) begin
         sum_in = sum_ff + SW'(rd_val);
         if (rd_val < lo_ff) begin
            lo_in = rd_val;
         end
         if (rd_val > hi_ff) begin
            hi_in = rd_val;
         end
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mem_we  = 1'b1;
               slot_in = (slot_ff == LAST_ADDR) ? '0 : slot_ff + 1'b1;
               if (fill_ff != FILL_FULL) begin
                  fill_in = fill_ff + 1'b1;
               end
               sum_in   = '0;
               lo_in    = SAMPLE_MAX;
               hi_in    = '0;
               addr_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_pend_in = 1'b1;
            rd_live_in = (FW'(addr_ff) < fill_ff);
            if (addr_ff == LAST_ADDR) begin
               state_in = ST_DRAIN;
            end else begin
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            state_in = ST_MSTART;
         end
         ST_MSTART: begin
            div_start = 1'b1;
            state_in  = ST_MDIV;
         end
         ST_MDIV: begin
            if (div_done) begin
               mean_in  = div_quot[13:0];
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            t_in     = ORP_SCALE - T_W'(T_W'(mean_ff) * T_W'(MEAN_GAIN));
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            prod_in  = 35'($signed(t_ff)) * 35'($signed({1'b0, vref_ff}));
            ofs_in   = 34'($signed(offset_ff)) * 34'($signed({1'b0, ORP_DEN}));
            state_in = ST_SUB;
         end
         ST_SUB: begin
            num_in   = NUM_W'(prod_ff) - NUM_W'(ofs_ff);
            state_in = ST_OSTART;
         end
         ST_OSTART: begin
            div_start = 1'b1;
            div_orp   = 1'b1;
            state_in  = ST_ODIV;
         end
         ST_ODIV: begin
            div_orp = 1'b1;
            if (div_done) begin
               omag_in  = div_quot;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               mean_out_in  = mean_ff;
               if (num_ff[NUM_W-1]) begin
                  orp_out_in = (omag_ff > ORP_NEG_LIM) ? ORP_MIN
                                                      : 14'(~omag_ff + 1'b1);
               end else begin
                  orp_out_in = (omag_ff > ORP_POS_LIM) ? ORP_MAX : 14'(omag_ff);
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[slot_ff] <= req_tdata[9:0];
      end
      rd_data_ff <= ring_mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         slot_ff      <= '0;
         fill_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_live_ff  <= rd_live_in;
      sum_ff      <= sum_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      mean_ff     <= mean_in;
      t_ff        <= t_in;
      prod_ff     <= prod_in;
      ofs_ff      <= ofs_in;
      num_ff      <= num_in;
      omag_ff     <= omag_in;
      orp_out_ff  <= orp_out_in;
      mean_out_ff <= mean_out_in;
   end

   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         vref_ff   <= VREF_RESET;
         offset_ff <= OFFSET_RESET;
      end else if (csr_wr) begin
         case (csr_paddr[2])
            CSR_VREF_IDX:   vref_ff   <= csr_pwdata[12:0];
            CSR_OFFSET_IDX: offset_ff <= csr_pwdata[11:0];
            default: begin
               vref_ff <= vref_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_paddr[2])
         CSR_VREF_IDX:   csr_prdata = {19'd0, vref_ff};
         CSR_OFFSET_IDX: csr_prdata = {{20{offset_ff[11]}}, offset_ff};
         default:        csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'd0, mean_out_ff, orp_out_ff};

   a_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff == ST_SCAN))
      else $error("request accepted without starting the ring walk");

   a_read_origin: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> ($past(state_ff) == ST_SCAN))
      else $error("ring read folded in outside the walk");

   a_div_owner: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_MDIV || state_ff == ST_ODIV))
      else $error("divider finished with no waiting stage");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_FULL)
      else $error("fill count beyond ring depth");

endmodule
